// ===== hw/rtl/sppd_pkg.sv =====
// Types, codes and helper functions of the sprite planar pixel decoder.
`default_nettype none

package sppd_pkg;

   // Request kinds
   localparam logic [1:0] REQ_VIDEO_WRITE  = 2'd0;
   localparam logic [1:0] REQ_COLOUR_WRITE = 2'd1;
   localparam logic [1:0] REQ_RENDER       = 2'd2;

   // Register indexes
   localparam logic CSR_BACKGROUND_MODE    = 1'b0;
   localparam logic CSR_SPRITE_ACCESS_MODE = 1'b1;

   // Background mode codes (anything else shows magenta)
   localparam logic [1:0] BG_GREY  = 2'd0;
   localparam logic [1:0] BG_BLACK = 2'd1;

   // Access mode code for the two-plane fetch
   localparam logic [1:0] ACCESS_TWO_PLANE = 2'd1;

   // Attribute bits
   localparam int ATTR_VFLIP = 15;
   localparam int ATTR_HFLIP = 11;

   // Span of a four-plane fetch, in words (planes lie 16 words apart)
   localparam logic [17:0] FETCH_SPAN = 18'd48;

   localparam logic [7:0] GREY_LEVEL = 8'd128;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [14:0] write_addr;
      logic [15:0] write_data;
      logic [15:0] sprite_attr;
      logic [15:0] pattern_addr;
      logic        pattern_low_bit;
      logic [5:0]  sprite_width;
      logic [6:0]  sprite_height;
      logic [4:0]  pixel_x;
      logic [5:0]  pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       drawn;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FLIP,
      S_ROW,
      S_COL,
      S_BOUND,
      S_FETCH,
      S_DRAIN,
      S_COLOR,
      S_EXPAND,
      S_RESP
   } state_type;

   // 3-bit level to 8 bits: v * 255 / 7
   function automatic logic [7:0] expand3(input logic [2:0] v);
      logic [7:0] r;
      unique case (v)
         3'd0: r = 8'd0;
         3'd1: r = 8'd36;
         3'd2: r = 8'd72;
         3'd3: r = 8'd109;
         3'd4: r = 8'd145;
         3'd5: r = 8'd182;
         3'd6: r = 8'd218;
         3'd7: r = 8'd255;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sprite_planar_pixel_decoder_top.sv =====
// Top level of the sprite planar pixel decoder: sequencer, shared adder and memories.
`default_nettype none

// Decodes one pixel of a 4bpp planar sprite pattern held in an internal video word
// memory, and looks its colour up in a 512-entry colour table. Requests of kind
// video write and colour write store one word or entry; they give no response. A
// render request runs a sequencer around one shared 18-bit adder: flip, row
// address, column and plane-pair offset, bound check, then one video memory read
// per plane on the single memory port (four planes, or two in the two-plane mode),
// a drain step for the registered read, the colour index decode and, for opaque
// pixels, the registered colour table read. A pixel outside the sprite goes
// straight to the response after the flip step, and a fetch past the end of
// memory after the bound check. The response is held until rsp_ready.
// req_ready is low from the accepted render request until its response is
// taken. Memories come up undefined; read only what was written. Configuration
// writes are taken at any time but must only happen while the block is idle.
module sprite_planar_pixel_decoder_top #(
   parameter int VIDEO_WORDS = 32768
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  sppd_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output sppd_pkg::rsp_payload_type  rsp_payload,
   input  wire                        csr_we,
   input  wire                        csr_index,
   input  wire  [1:0]                 csr_wdata
);

   localparam int AW = $clog2(VIDEO_WORDS);
   localparam logic [17:0] VW_LIMIT = 18'(VIDEO_WORDS);

   // ---------------------------------------------------------------- registers
   sppd_pkg::state_type       state_ff, state_in;
   logic [1:0]                bg_mode_ff, bg_mode_in;
   logic [1:0]                access_mode_ff, access_mode_in;
   sppd_pkg::req_payload_type req_ff, req_in;
   logic [5:0]                fx_ff, fx_in;
   logic [6:0]                fy_ff, fy_in;
   logic [16:0]               line_ff, line_in;
   logic [1:0]                plane_ff, plane_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [1:0]                rd_plane_ff, rd_plane_in;
   logic [3:0]                bits_ff, bits_in;
   sppd_pkg::rsp_payload_type rsp_ff, rsp_in;

   // memories and their registered read data
   logic [15:0] video_mem [VIDEO_WORDS];
   logic [8:0]  colour_mem [512];
   logic [15:0] vdata_ff;
   logic [8:0]  cdata_ff;

   // ---------------------------------------------------------------- decode
   logic req_fire, rsp_fire, two_plane;
   logic vid_wr, col_wr, vid_rd, col_rd;
   logic [16:0] wr_addr_ext;
   logic [AW-1:0] vid_addr;
   logic [8:0] col_addr;
   logic last_plane;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign two_plane = (access_mode_ff == sppd_pkg::ACCESS_TWO_PLANE);
   assign last_plane = two_plane ? (plane_ff == 2'd1) : (plane_ff == 2'd3);

   // ---------------------------------------------------------------- shared adder
   // One adder serves the row, column, bound and per-plane address steps.
   logic [17:0] add_a, add_b, add_sum;
   logic        past_end;

   always_comb begin
      add_a = {1'b0, line_ff};
      add_b = '0;
      unique case (state_ff)
         sppd_pkg::S_ROW: begin
            add_a = {2'b00, req_ff.pattern_addr};
            add_b = {8'd0, fy_ff[6:4], 3'b000, fy_ff[3:0]};
         end
         sppd_pkg::S_COL: begin
            add_b = {10'd0, fx_ff[5:4], two_plane & req_ff.pattern_low_bit, 5'd0};
         end
         sppd_pkg::S_BOUND: add_b = sppd_pkg::FETCH_SPAN;
         sppd_pkg::S_FETCH: add_b = {12'd0, plane_ff, 4'd0};
         default: add_b = '0;
      endcase
   end

   assign add_sum  = add_a + add_b;
   assign past_end = (add_sum >= VW_LIMIT);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sppd_pkg::S_IDLE:
            if (req_fire && req_payload.req_type == sppd_pkg::REQ_RENDER) begin
               state_in = sppd_pkg::S_FLIP;
            end
         sppd_pkg::S_FLIP:
            if (({1'b0, req_ff.pixel_x} >= req_ff.sprite_width) ||
                ({1'b0, req_ff.pixel_y} >= req_ff.sprite_height)) begin
               state_in = sppd_pkg::S_RESP;
            end else begin
               state_in = sppd_pkg::S_ROW;
            end
         sppd_pkg::S_ROW:   state_in = sppd_pkg::S_COL;
         sppd_pkg::S_COL:   state_in = sppd_pkg::S_BOUND;
         sppd_pkg::S_BOUND: state_in = past_end ? sppd_pkg::S_RESP : sppd_pkg::S_FETCH;
         sppd_pkg::S_FETCH: if (last_plane) state_in = sppd_pkg::S_DRAIN;
         sppd_pkg::S_DRAIN: state_in = sppd_pkg::S_COLOR;
         sppd_pkg::S_COLOR:
            state_in = (bits_ff == 4'd0) ? sppd_pkg::S_RESP : sppd_pkg::S_EXPAND;
         sppd_pkg::S_EXPAND: state_in = sppd_pkg::S_RESP;
         sppd_pkg::S_RESP:   if (rsp_fire) state_in = sppd_pkg::S_IDLE;
         default: state_in = sppd_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_ready = (state_ff == sppd_pkg::S_IDLE);
      rsp_valid = (state_ff == sppd_pkg::S_RESP);
      vid_rd    = (state_ff == sppd_pkg::S_FETCH);
      col_rd    = (state_ff == sppd_pkg::S_COLOR) && (bits_ff != 4'd0);
   end

   assign rsp_payload = rsp_ff;

   // writes: out-of-range video addresses are dropped
   assign wr_addr_ext = {2'b00, req_payload.write_addr};
   assign vid_wr = req_fire && (req_payload.req_type == sppd_pkg::REQ_VIDEO_WRITE) &&
                   ({1'b0, wr_addr_ext} < VW_LIMIT);
   assign col_wr = req_fire && (req_payload.req_type == sppd_pkg::REQ_COLOUR_WRITE);
   assign vid_addr = vid_wr ? wr_addr_ext[AW-1:0] : add_sum[AW-1:0];
   assign col_addr = col_wr ? req_payload.write_addr[8:0] : {1'b1, req_ff.sprite_attr[3:0],
                                                             bits_ff};

   // ---------------------------------------------------------------- datapath
   always_comb begin
      bg_mode_in     = bg_mode_ff;
      access_mode_in = access_mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            sppd_pkg::CSR_BACKGROUND_MODE:    bg_mode_in = csr_wdata;
            sppd_pkg::CSR_SPRITE_ACCESS_MODE: access_mode_in = csr_wdata;
            default: ;
         endcase
      end

      req_in      = req_ff;
      fx_in       = fx_ff;
      fy_in       = fy_ff;
      line_in     = line_ff;
      plane_in    = plane_ff;
      bits_in     = bits_ff;
      rsp_in      = rsp_ff;
      rd_valid_in = vid_rd;
      rd_plane_in = plane_ff;

      // capture the plane bit in the cycle after its read; the leftmost pixel is bit 15
      if (rd_valid_ff) begin
         bits_in[rd_plane_ff] = vdata_ff[~fx_ff[3:0]];
      end

      unique case (state_ff)
         sppd_pkg::S_IDLE: begin
            req_in   = req_payload;
            plane_in = 2'd0;
            bits_in  = 4'd0;
            rsp_in   = '0;
         end
         sppd_pkg::S_FLIP: begin
            fx_in = req_ff.sprite_attr[sppd_pkg::ATTR_HFLIP] ?
                    6'(req_ff.sprite_width - 6'd1 - {1'b0, req_ff.pixel_x}) :
                    {1'b0, req_ff.pixel_x};
            fy_in = req_ff.sprite_attr[sppd_pkg::ATTR_VFLIP] ?
                    7'(req_ff.sprite_height - 7'd1 - {1'b0, req_ff.pixel_y}) :
                    {1'b0, req_ff.pixel_y};
         end
         sppd_pkg::S_ROW: line_in = {1'b0, add_sum[15:0]};   // wraps at 16 bits
         sppd_pkg::S_COL: line_in = add_sum[16:0];
         sppd_pkg::S_FETCH: plane_in = plane_ff + 2'd1;
         sppd_pkg::S_COLOR: begin
            if (bits_ff == 4'd0) begin
               rsp_in.drawn = 1'b1;
               priority case (bg_mode_ff)
                  sppd_pkg::BG_GREY: begin
                     rsp_in.red   = sppd_pkg::GREY_LEVEL;
                     rsp_in.green = sppd_pkg::GREY_LEVEL;
                     rsp_in.blue  = sppd_pkg::GREY_LEVEL;
                  end
                  sppd_pkg::BG_BLACK: begin
                     rsp_in.red   = 8'd0;
                     rsp_in.green = 8'd0;
                     rsp_in.blue  = 8'd0;
                  end
                  default: begin
                     rsp_in.red   = 8'd255;
                     rsp_in.green = 8'd0;
                     rsp_in.blue  = 8'd255;
                  end
               endcase
            end
         end
         sppd_pkg::S_EXPAND: begin
            // entry layout GGGRRRBBB
            rsp_in.drawn = 1'b1;
            rsp_in.red   = sppd_pkg::expand3(cdata_ff[5:3]);
            rsp_in.green = sppd_pkg::expand3(cdata_ff[8:6]);
            rsp_in.blue  = sppd_pkg::expand3(cdata_ff[2:0]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sppd_pkg::S_IDLE;
         bg_mode_ff     <= 2'd0;
         access_mode_ff <= 2'd0;
         rd_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bg_mode_ff     <= bg_mode_in;
         access_mode_ff <= access_mode_in;
         rd_valid_ff    <= rd_valid_in;
      end
      req_ff      <= req_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      line_ff     <= line_in;
      plane_ff    <= plane_in;
      rd_plane_ff <= rd_plane_in;
      bits_ff     <= bits_in;
      rsp_ff      <= rsp_in;
   end

   // ---------------------------------------------------------------- memories
   // single port video memory
   always_ff @(posedge clock) begin
      if (vid_wr) begin
         video_mem[vid_addr] <= req_payload.write_data;
      end else if (vid_rd) begin
         vdata_ff <= video_mem[vid_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (col_wr) begin
         colour_mem[col_addr] <= req_payload.write_data[8:0];
      end else if (col_rd) begin
         cdata_ff <= colour_mem[col_addr];
      end
   end

   // ---------------------------------------------------------------- assertions
   a_ready_xor_resp: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_fetch_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sppd_pkg::S_FETCH) |-> ((18'(line_ff) + sppd_pkg::FETCH_SPAN) < VW_LIMIT))
      else $error("plane fetch past the end of video memory");

   a_read_follows_fetch: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == sppd_pkg::S_FETCH))
      else $error("plane capture without a fetch");

   a_two_plane_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sppd_pkg::S_DRAIN && two_plane) |-> (bits_ff[3:2] == 2'b00))
      else $error("upper planes set in two-plane mode");

endmodule

`default_nettype wire
